>>> src/dtsrp_pkg.sv
`timescale 1ns / 1ps

package dtsrp_pkg;

  localparam int unsigned COLUMNS   = 64;
  localparam int unsigned ROWS      = 180;
  localparam int unsigned ROW_W     = 8;
  localparam int unsigned SMP_W     = 24;
  localparam int unsigned RM_W      = 23;
  localparam int unsigned XO_W      = 9;
  localparam int unsigned COLUMN_W  = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 23;
  localparam int unsigned COL_W     = $clog2(COLUMNS);
  localparam int unsigned CNT_W     = $clog2(COLUMNS + 1);
  localparam int unsigned PROD_W    = RM_W + ROW_W;
  localparam int unsigned NUM_W     = PROD_W + 1;

  localparam logic [ROW_W-1:0] EMPTY   = 8'hFF;
  localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(ROWS - 1);

  localparam logic [RM_W-1:0] RANGE_MAX_RESET = RM_W'(25600);
  localparam logic [XO_W-1:0] X_ORIGIN_RESET  = '0;

  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN  = CFG_IDX_W'(1);

  typedef struct packed {
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    span_low;
    logic [ROW_W-1:0]    span_high;
    logic                green_valid;
    logic [ROW_W-1:0]    green_top;
    logic [ROW_W-1:0]    green_bottom;
    logic                blue_valid;
    logic [ROW_W-1:0]    blue_top;
    logic [ROW_W-1:0]    blue_bottom;
    logic                last;
  } cmd_t;

endpackage

>>> src/dtsrp_row_div.sv
`timescale 1ns / 1ps

module dtsrp_row_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [dtsrp_pkg::SMP_W-1:0] sample_i,
  input  logic [dtsrp_pkg::RM_W-1:0]       range_max_i,
  output logic                             done_o,
  output logic [dtsrp_pkg::ROW_W-1:0]      row_o
);
  import dtsrp_pkg::*;

  localparam int unsigned STEP_W = $clog2(ROW_W);

  typedef enum logic [1:0] {D_IDLE, D_MUL, D_ADD, D_DIV} div_state_e;

  div_state_e          state_q, state_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                done_q, done_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [RM_W-1:0]     g_q, r_q, g_clamp;
  logic [PROD_W-1:0]   prod_q;
  logic [NUM_W-1:0]    rem_q, rem_d;
  logic [ROW_W-1:0]    quo_q, quo_d;
  logic [NUM_W-1:0]    div_sub;
  logic                fits;

  always_comb begin
    if (sample_i[SMP_W-1]) begin
      g_clamp = '0;
    end else if (sample_i[RM_W-1:0] > range_max_i) begin
      g_clamp = range_max_i;
    end else begin
      g_clamp = sample_i[RM_W-1:0];
    end
  end

  assign div_sub = NUM_W'(r_q) << step_q;
  assign fits    = rem_q >= div_sub;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    done_d  = 1'b0;
    row_d   = row_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    unique case (state_q)
      D_IDLE: begin
        if (start_i) state_d = D_MUL;
      end
      D_MUL: begin
        state_d = D_ADD;
      end
      D_ADD: begin
        rem_d   = NUM_W'(prod_q) + NUM_W'(r_q) - NUM_W'(1);
        quo_d   = '0;
        step_d  = STEP_W'(ROW_W - 1);
        state_d = D_DIV;
      end
      D_DIV: begin
        quo_d[step_q] = fits;
        if (fits) rem_d = rem_q - div_sub;
        if (step_q == '0) begin
          row_d   = (r_q == '0) ? ROW_MAX : ROW_MAX - quo_d;
          done_d  = 1'b1;
          state_d = D_IDLE;
        end else begin
          step_d = step_q - STEP_W'(1);
        end
      end
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= done_d;
      row_q   <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == D_IDLE && start_i) begin
      g_q <= g_clamp;
      r_q <= range_max_i;
    end
    if (state_q == D_MUL) prod_q <= PROD_W'(g_q) * PROD_W'(ROW_MAX);
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign row_o  = row_q;

endmodule

>>> src/dtsrp_col_walk.sv
`timescale 1ns / 1ps

module dtsrp_col_walk (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [dtsrp_pkg::ROW_W-1:0]   green_row_i,
  input  logic [dtsrp_pkg::ROW_W-1:0]   blue_row_i,
  input  logic [dtsrp_pkg::XO_W-1:0]    x_origin_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output dtsrp_pkg::cmd_t               out_cmd_o,
  output logic                          done_o
);
  import dtsrp_pkg::*;

  localparam int unsigned PT_W = 2 * ROW_W;
  localparam int unsigned DR_W = 4 * ROW_W;
  localparam int unsigned SUM_W = COL_W + 1;

  typedef enum logic [1:0] {W_IDLE, W_LOAD, W_RUN, W_FLUSH} walk_state_e;

  logic [PT_W-1:0] pt_mem [COLUMNS];
  logic [DR_W-1:0] dr_mem [COLUMNS];

  walk_state_e        state_q, state_d;
  logic [COL_W-1:0]   base_q, base_d;
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic [CNT_W-1:0]   rc_q, rc_d;
  logic               iss_q, iss_d;
  logic               s1_vld_q, s1_vld_d;
  logic [CNT_W-1:0]   s1_rc_q, s1_rc_d;
  logic               pv1_q, pv1_d;
  logic               prev_pv_q, prev_pv_d;
  logic               pend_vld_q, pend_vld_d;
  logic               out_vld_q, out_vld_d;
  logic               done_q, done_d;
  logic [COLUMNS-1:0] dvld_q;
  logic               dvld_rd_q;
  logic [PT_W-1:0]    pt_rd_q, prev_pt_q;
  logic [DR_W-1:0]    dr_rd_q;
  cmd_t               pend_q, pend_d, out_q, out_d, cmd;

  logic               pt_we, pt_re, dr_we, dr_re;
  logic [SUM_W-1:0]   addr_sum;
  logic [COL_W-1:0]   pt_addr, dr_idx, wr_col;
  logic               col_filled, out_free, adv, cmd_vld, changed;
  logic [ROW_W-1:0]   g_y, g_n, b_y, b_n, gt, gb, bt, bb;
  logic [ROW_W-1:0]   dgt, dgb, dbt, dbb, lo, hi;
  logic [DR_W-1:0]    dr_word;

  assign addr_sum   = SUM_W'(base_q) + SUM_W'(rc_q);
  assign pt_addr    = (addr_sum >= SUM_W'(COLUMNS)) ? COL_W'(addr_sum - SUM_W'(COLUMNS))
                                                    : COL_W'(addr_sum);
  assign dr_idx     = COL_W'(rc_q - CNT_W'(1));
  assign wr_col     = COL_W'(s1_rc_q - CNT_W'(1));
  assign col_filled = (rc_q < CNT_W'(COLUMNS)) &&
                      ((CNT_W + 1)'(rc_q) + (CNT_W + 1)'(fill_q) >= (CNT_W + 1)'(COLUMNS));

  assign g_y = prev_pt_q[PT_W-1:ROW_W];
  assign b_y = prev_pt_q[ROW_W-1:0];
  assign g_n = pv1_q ? pt_rd_q[PT_W-1:ROW_W] : g_y;
  assign b_n = pv1_q ? pt_rd_q[ROW_W-1:0] : b_y;
  assign gt  = (g_y < g_n) ? g_y : g_n;
  assign gb  = (g_y < g_n) ? g_n : g_y;
  assign bt  = (b_y < b_n) ? b_y : b_n;
  assign bb  = (b_y < b_n) ? b_n : b_y;

  assign dr_word = dvld_rd_q ? dr_rd_q : {4{EMPTY}};
  assign dgt = dr_word[4*ROW_W-1:3*ROW_W];
  assign dgb = dr_word[3*ROW_W-1:2*ROW_W];
  assign dbt = dr_word[2*ROW_W-1:ROW_W];
  assign dbb = dr_word[ROW_W-1:0];

  assign changed = prev_pv_q && (dgt != gt || dgb != gb || dbt != bt || dbb != bb);
  assign cmd_vld = state_q == W_RUN && s1_vld_q && s1_rc_q != '0 && changed;

  always_comb begin
    lo = (gt < bt) ? gt : bt;
    hi = (gb > bb) ? gb : bb;
    if (dgt != EMPTY) begin
      if (dgt < lo) lo = dgt;
      if (dgb > hi) hi = dgb;
    end
    if (dbt != EMPTY) begin
      if (dbt < lo) lo = dbt;
      if (dbb > hi) hi = dbb;
    end
  end

  always_comb begin
    cmd.column       = COLUMN_W'(x_origin_i) + COLUMN_W'(wr_col);
    cmd.span_low     = lo;
    cmd.span_high    = hi;
    cmd.green_valid  = prev_pv_q;
    cmd.green_top    = prev_pv_q ? gt : '0;
    cmd.green_bottom = prev_pv_q ? gb : '0;
    cmd.blue_valid   = prev_pv_q;
    cmd.blue_top     = prev_pv_q ? bt : '0;
    cmd.blue_bottom  = prev_pv_q ? bb : '0;
    cmd.last         = 1'b0;
  end

  assign out_free = !out_vld_q || out_ready_i;
  assign adv      = !cmd_vld || !pend_vld_q || out_free;

  always_comb begin
    state_d    = state_q;
    base_d     = base_q;
    fill_d     = fill_q;
    rc_d       = rc_q;
    iss_d      = iss_q;
    s1_vld_d   = s1_vld_q;
    s1_rc_d    = s1_rc_q;
    pv1_d      = pv1_q;
    prev_pv_d  = prev_pv_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    done_d     = 1'b0;
    pt_we      = 1'b0;
    pt_re      = 1'b0;
    dr_we      = 1'b0;
    dr_re      = 1'b0;
    unique case (state_q)
      W_IDLE: begin
        if (start_i) state_d = W_LOAD;
      end
      W_LOAD: begin
        pt_we    = 1'b1;
        base_d   = (base_q == COL_W'(COLUMNS - 1)) ? '0 : base_q + COL_W'(1);
        if (fill_q != CNT_W'(COLUMNS)) fill_d = fill_q + CNT_W'(1);
        rc_d     = '0;
        iss_d    = 1'b1;
        s1_vld_d = 1'b0;
        state_d  = W_RUN;
      end
      W_RUN: begin
        if (adv) begin
          if (iss_q) begin
            pt_re    = rc_q < CNT_W'(COLUMNS);
            dr_re    = rc_q != '0;
            s1_vld_d = 1'b1;
            s1_rc_d  = rc_q;
            pv1_d    = col_filled;
            rc_d     = rc_q + CNT_W'(1);
            iss_d    = rc_q != CNT_W'(COLUMNS);
          end else begin
            s1_vld_d = 1'b0;
          end
          if (s1_vld_q) prev_pv_d = pv1_q;
          if (cmd_vld) begin
            dr_we = 1'b1;
            if (pend_vld_q) begin
              out_d     = pend_q;
              out_vld_d = 1'b1;
            end
            pend_d     = cmd;
            pend_vld_d = 1'b1;
          end
          if (s1_vld_q && s1_rc_q == CNT_W'(COLUMNS)) state_d = W_FLUSH;
        end
      end
      W_FLUSH: begin
        if (!pend_vld_q) begin
          done_d  = 1'b1;
          state_d = W_IDLE;
        end else if (out_free) begin
          out_d      = pend_q;
          out_d.last = 1'b1;
          out_vld_d  = 1'b1;
          pend_vld_d = 1'b0;
          done_d     = 1'b1;
          state_d    = W_IDLE;
        end
      end
      default: state_d = W_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= W_IDLE;
      base_q     <= '0;
      fill_q     <= '0;
      rc_q       <= '0;
      iss_q      <= 1'b0;
      s1_vld_q   <= 1'b0;
      s1_rc_q    <= '0;
      pv1_q      <= 1'b0;
      prev_pv_q  <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      done_q     <= 1'b0;
      dvld_q     <= '0;
      dvld_rd_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      base_q     <= base_d;
      fill_q     <= fill_d;
      rc_q       <= rc_d;
      iss_q      <= iss_d;
      s1_vld_q   <= s1_vld_d;
      s1_rc_q    <= s1_rc_d;
      pv1_q      <= pv1_d;
      prev_pv_q  <= prev_pv_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      done_q     <= done_d;
      if (dr_we) dvld_q[wr_col] <= 1'b1;
      if (dr_re) dvld_rd_q <= dvld_q[dr_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
    if (state_q == W_RUN && adv && s1_vld_q) prev_pt_q <= pt_rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (pt_we) pt_mem[base_q] <= {green_row_i, blue_row_i};
    if (pt_re) pt_rd_q <= pt_mem[pt_addr];
  end

  always_ff @(posedge clk_i) begin
    if (dr_we) dr_mem[wr_col] <= {gt, gb, bt, bb};
    if (dr_re) dr_rd_q <= dr_mem[dr_idx];
  end

  assign out_valid_o = out_vld_q;
  assign out_cmd_o   = out_q;
  assign done_o      = done_q;

endmodule

>>> src/dual_trace_scroll_redraw_planner_top.sv
`timescale 1ns / 1ps
// Dual-trace scrolling redraw planner.
// Input channel: one beat carries a green and a blue sample (signed Q15.8).
// A beat is taken only while the block is idle; one sample pair is in work
// at a time. Both samples map to rows in two parallel dividers: load,
// multiply, offset, then eight quotient steps. The new points are then
// written to the point memory and all COLUMNS columns are walked, one per
// cycle unless the output holds the walk, through the point and drawn-span
// memories.
// Output channel: one beat per changed column, left to right, from a
// register; last marks the final beat of a sample. A sample with no change
// sends no beat. If a new command is ready while both the pending and the
// output register are full, the walk holds until the receiver takes the beat.
// Configuration channel: always ready; index 0 is range_max, index 1 is
// x_origin, other indexes are dropped. Write only while idle.
// Reset: range_max 25600, x_origin 0, all columns empty and never drawn.

module dual_trace_scroll_redraw_planner_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [dtsrp_pkg::SMP_W-1:0]     sample_green_i,
  input  logic signed [dtsrp_pkg::SMP_W-1:0]     sample_blue_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [dtsrp_pkg::COLUMN_W-1:0]         column_o,
  output logic [dtsrp_pkg::ROW_W-1:0]            span_low_o,
  output logic [dtsrp_pkg::ROW_W-1:0]            span_high_o,
  output logic                                   green_valid_o,
  output logic [dtsrp_pkg::ROW_W-1:0]            green_top_o,
  output logic [dtsrp_pkg::ROW_W-1:0]            green_bottom_o,
  output logic                                   blue_valid_o,
  output logic [dtsrp_pkg::ROW_W-1:0]            blue_top_o,
  output logic [dtsrp_pkg::ROW_W-1:0]            blue_bottom_o,
  output logic                                   last_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [dtsrp_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [dtsrp_pkg::CFG_W-1:0]            cfg_data_i
);
  import dtsrp_pkg::*;

  typedef enum logic [1:0] {T_IDLE, T_DIV, T_WALK} top_state_e;

  top_state_e       state_q;
  logic [RM_W-1:0]  range_max_q;
  logic [XO_W-1:0]  x_origin_q;
  logic             in_acc, g_done, b_done, walk_start, walk_done;
  logic [ROW_W-1:0] g_row, b_row;
  cmd_t             cmd;

  assign in_ready_o  = state_q == T_IDLE;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign walk_start  = state_q == T_DIV && g_done && b_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      range_max_q <= RANGE_MAX_RESET;
      x_origin_q  <= X_ORIGIN_RESET;
    end else begin
      unique case (state_q)
        T_IDLE:  if (in_acc) state_q <= T_DIV;
        T_DIV:   if (walk_start) state_q <= T_WALK;
        T_WALK:  if (walk_done) state_q <= T_IDLE;
        default: state_q <= T_IDLE;
      endcase
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_RANGE_MAX: range_max_q <= cfg_data_i[RM_W-1:0];
          CFG_X_ORIGIN:  x_origin_q  <= cfg_data_i[XO_W-1:0];
          default: ;
        endcase
      end
    end
  end

  dtsrp_row_div u_div_green (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_acc),
    .sample_i    (sample_green_i),
    .range_max_i (range_max_q),
    .done_o      (g_done),
    .row_o       (g_row)
  );

  dtsrp_row_div u_div_blue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_acc),
    .sample_i    (sample_blue_i),
    .range_max_i (range_max_q),
    .done_o      (b_done),
    .row_o       (b_row)
  );

  dtsrp_col_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (walk_start),
    .green_row_i (g_row),
    .blue_row_i  (b_row),
    .x_origin_i  (x_origin_q),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_cmd_o   (cmd),
    .done_o      (walk_done)
  );

  assign column_o       = cmd.column;
  assign span_low_o     = cmd.span_low;
  assign span_high_o    = cmd.span_high;
  assign green_valid_o  = cmd.green_valid;
  assign green_top_o    = cmd.green_top;
  assign green_bottom_o = cmd.green_bottom;
  assign blue_valid_o   = cmd.blue_valid;
  assign blue_top_o     = cmd.blue_top;
  assign blue_bottom_o  = cmd.blue_bottom;
  assign last_o         = cmd.last;

endmodule

>>> src/dtsrp_checker.sv
`timescale 1ns / 1ps

module dtsrp_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic signed [dtsrp_pkg::SMP_W-1:0]  sample_green_i,
  input logic signed [dtsrp_pkg::SMP_W-1:0]  sample_blue_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [dtsrp_pkg::COLUMN_W-1:0]      column_o,
  input logic [dtsrp_pkg::ROW_W-1:0]         span_low_o,
  input logic [dtsrp_pkg::ROW_W-1:0]         span_high_o,
  input logic                                green_valid_o,
  input logic [dtsrp_pkg::ROW_W-1:0]         green_top_o,
  input logic [dtsrp_pkg::ROW_W-1:0]         green_bottom_o,
  input logic                                blue_valid_o,
  input logic [dtsrp_pkg::ROW_W-1:0]         blue_top_o,
  input logic [dtsrp_pkg::ROW_W-1:0]         blue_bottom_o,
  input logic                                last_o,
  input logic                                cfg_valid_i,
  input logic                                cfg_ready_o,
  input logic [dtsrp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input logic [dtsrp_pkg::CFG_W-1:0]         cfg_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(column_o) && $stable(last_o))
    else $error("output beat changed while stalled");

  a_busy_mid_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("input ready before the last beat of a sample");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after an accepted beat");

  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> span_low_o <= span_high_o && green_top_o <= green_bottom_o &&
                    blue_top_o <= blue_bottom_o)
    else $error("span bounds out of order");

endmodule

bind dual_trace_scroll_redraw_planner_top dtsrp_checker u_dtsrp_checker (.*);
